// File: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational implication checked at every rising edge outside reset
`define KIS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key index sorter assertion failed");

// next-cycle implication checked at every rising edge outside reset
`define KIS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key index sorter assertion failed");

`endif

// File: hw/rtl/kis_pkg.sv
// shared constants and types of the key index sorter
package kis_pkg;

	localparam int MAX_ITEMS_DEF  = 64;
	localparam int TAG_BITS_DEF   = 16;
	localparam int KEY_BITS       = 64;
	localparam int TAG_FIELD_BITS = 16;

	// side information of a drain read, travels with the read data
	typedef struct packed {
		logic valid;
		logic last;
		logic ovf;
	} kis_rd_meta_t;

	// output buffer status back to the sequencer
	typedef struct packed {
		logic       space;
		logic [1:0] occ;
	} kis_ob_stat_t;

endpackage

// File: hw/rtl/key_index_sorter_unit.sv
// top level of the key index sorter: stable ascending sort of keyed items
// Loads a set of signed 64-bit keys with tags, one request per accepted beat on
// the slave stream; the beat with tlast closes the set. While loading, each item
// is inserted into a single key/tag store by a downward scan: the store has one
// write and one registered read port, so one entry moves per cycle. The first
// item of a set is written directly; any other item reads the top entry, shifts
// each stored key strictly greater than it one place up and is written into the
// gap. Equal keys keep arrival order. After the closing item the sorted set
// drains one result per cycle while the two-entry output buffer has space,
// and the next set may start loading as soon as the last drain read is issued.
// Items beyond MAX_ITEMS are dropped and every result of that set has tuser set.
// No clearing pass after reset: stale store entries are never read.
module key_index_sorter_unit #(
	parameter int MAX_ITEMS = kis_pkg::MAX_ITEMS_DEF,
	parameter int TAG_BITS  = kis_pkg::TAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// item requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // sort_key[63:0], item_tag[79:64]
	input  logic        s_tlast,   // final_item
	// sorted results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // sorted_key[63:0], sorted_tag[79:64]
	output logic        m_tlast,   // last_result
	output logic        m_tuser    // overflowed
);

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int KW = kis_pkg::KEY_BITS;
	localparam int TF = kis_pkg::TAG_FIELD_BITS;
	localparam int DW = KW + TAG_BITS;

	// tag field resized to the stored width, zero filled when wider
	logic [TAG_BITS+TF-1:0] in_tag_ext;
	logic [TAG_BITS-1:0]    in_tag;

	logic                   mem_we;
	logic [IW-1:0]          mem_waddr;
	logic [DW-1:0]          mem_wdata;
	logic                   mem_re;
	logic [IW-1:0]          mem_raddr;
	logic [DW-1:0]          mem_rdata;

	kis_pkg::kis_rd_meta_t  rd_meta_s1;
	kis_pkg::kis_ob_stat_t  ob_stat;

	logic [DW-1:0]          out_data;
	logic [TF+TAG_BITS-1:0] out_tag_ext;

	assign in_tag_ext = {{TAG_BITS{1'b0}}, s_tdata[KW+TF-1:KW]};
	assign in_tag     = in_tag_ext[TAG_BITS-1:0];

	kis_ctrl #(
		.MAX_ITEMS (MAX_ITEMS),
		.TAG_BITS  (TAG_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_key     (s_tdata[KW-1:0]),
		.in_tag     (in_tag),
		.in_final   (s_tlast),
		.ob_stat    (ob_stat),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.rd_meta_s1 (rd_meta_s1)
	);

	// key/tag store, one entry per stored item
	kis_mem #(
		.MAX_ITEMS (MAX_ITEMS),
		.WIDTH     (DW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result buffer decouples drain reads from output stalls
	kis_outbuf #(
		.WIDTH (DW)
	) u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_meta_s1 (rd_meta_s1),
		.rdata      (mem_rdata),
		.ob_stat    (ob_stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_data),
		.out_last   (m_tlast),
		.out_ovf    (m_tuser)
	);

	assign out_tag_ext = {{TF{1'b0}}, out_data[DW-1:KW]};
	assign m_tdata     = {out_tag_ext[TF-1:0], out_data[KW-1:0]};

	`include "assert_macros.svh"

	// a drain result always comes from a read issued in the cycle before
	`KIS_ASSERT_IMPL(a_meta_follows_read, rd_meta_s1.valid, $past(mem_re))
	// drain reads never overlap insertion writes
	`KIS_ASSERT_IMPL(a_drain_not_writing, rd_meta_s1.valid, !$past(mem_we))
	// the output buffer never holds more than its two entries
	`KIS_ASSERT_IMPL(a_buf_bound, 1'b1, ob_stat.occ != 2'd3)
	// no new request is taken while drain reads are still pending
	`KIS_ASSERT_IMPL(a_no_load_in_drain, rd_meta_s1.valid && !rd_meta_s1.last, !s_tready)
	// a closing request always blocks the input on the next cycle
	`KIS_ASSERT_NEXT(a_close_blocks_input, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

// File: hw/rtl/kis_mem.sv
// key and tag store: one write port, one registered read port
module kis_mem #(
	parameter int MAX_ITEMS = kis_pkg::MAX_ITEMS_DEF,
	parameter int WIDTH     = kis_pkg::KEY_BITS + kis_pkg::TAG_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(MAX_ITEMS)-1:0] waddr,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         re,
	input  logic [$clog2(MAX_ITEMS)-1:0] raddr,
	output logic [WIDTH-1:0]             rdata
);

	logic [WIDTH-1:0] mem [MAX_ITEMS];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/kis_ctrl.sv
// sequencer: insertion into the store while loading, then ordered drain reads
module kis_ctrl #(
	parameter int MAX_ITEMS = kis_pkg::MAX_ITEMS_DEF,
	parameter int TAG_BITS  = kis_pkg::TAG_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [kis_pkg::KEY_BITS-1:0]            in_key,
	input  logic [TAG_BITS-1:0]                     in_tag,
	input  logic                                    in_final,
	input  kis_pkg::kis_ob_stat_t                   ob_stat,
	output logic                                    mem_we,
	output logic [$clog2(MAX_ITEMS)-1:0]            mem_waddr,
	output logic [kis_pkg::KEY_BITS+TAG_BITS-1:0]   mem_wdata,
	output logic                                    mem_re,
	output logic [$clog2(MAX_ITEMS)-1:0]            mem_raddr,
	input  logic [kis_pkg::KEY_BITS+TAG_BITS-1:0]   mem_rdata,
	output kis_pkg::kis_rd_meta_t                   rd_meta_s1
);

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int KW = kis_pkg::KEY_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_INS   = 2'd1;
	localparam logic [1:0] ST_PLACE = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]       state_q;
	logic [CW-1:0]    cnt_q;
	logic             ovf_q;
	logic             final_q;
	logic [KW-1:0]    key_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [IW-1:0]    addr_s1;
	logic [IW-1:0]    drain_ptr_q;

	logic             accept;
	logic             room;
	logic [CW-1:0]    cnt_m1;
	logic             less;
	logic             drain_go;
	logic             drain_last;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid & in_ready;
	assign room       = (cnt_q < CW'(MAX_ITEMS));
	assign cnt_m1     = cnt_q - CW'(1);
	assign less       = $signed(key_q) < $signed(mem_rdata[KW-1:0]);
	assign drain_go   = (state_q == ST_DRAIN) & ob_stat.space;
	assign drain_last = (CW'(drain_ptr_q) == cnt_m1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = {tag_q, key_q};
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && room) begin
					if (cnt_q == '0) begin
						mem_we    = 1'b1;
						mem_wdata = {in_tag, in_key};
					end else begin
						mem_re    = 1'b1;
						mem_raddr = cnt_m1[IW-1:0];
					end
				end
			end
			ST_INS: begin
				mem_we    = 1'b1;
				mem_waddr = addr_s1 + IW'(1);
				if (less) begin
					// shift the larger entry up one place, keep scanning down
					mem_wdata = mem_rdata;
					if (addr_s1 != '0) begin
						mem_re    = 1'b1;
						mem_raddr = addr_s1 - IW'(1);
					end
				end
			end
			ST_PLACE: begin
				mem_we = 1'b1;
			end
			ST_DRAIN: begin
				mem_re    = drain_go;
				mem_raddr = drain_ptr_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= in_key;
			tag_q <= in_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			final_q     <= 1'b0;
			addr_s1     <= '0;
			drain_ptr_q <= '0;
			rd_meta_s1  <= '0;
		end else begin
			rd_meta_s1.valid <= drain_go;
			rd_meta_s1.last  <= drain_last;
			rd_meta_s1.ovf   <= ovf_q;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						final_q     <= in_final;
						drain_ptr_q <= '0;
						if (room) begin
							if (cnt_q == '0) begin
								cnt_q <= cnt_q + CW'(1);
								if (in_final) begin
									state_q <= ST_DRAIN;
								end
							end else begin
								addr_s1 <= cnt_m1[IW-1:0];
								state_q <= ST_INS;
							end
						end else begin
							ovf_q <= 1'b1;
							if (in_final) begin
								state_q <= ST_DRAIN;
							end
						end
					end
				end
				ST_INS: begin
					if (less) begin
						if (addr_s1 == '0) begin
							state_q <= ST_PLACE;
						end else begin
							addr_s1 <= addr_s1 - IW'(1);
						end
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= final_q ? ST_DRAIN : ST_IDLE;
					end
				end
				ST_PLACE: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= final_q ? ST_DRAIN : ST_IDLE;
				end
				ST_DRAIN: begin
					if (drain_go) begin
						drain_ptr_q <= drain_ptr_q + IW'(1);
						if (drain_last) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/kis_outbuf.sv
// two-entry result buffer between the store read port and the output stream
module kis_outbuf #(
	parameter int WIDTH = kis_pkg::KEY_BITS + kis_pkg::TAG_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kis_pkg::kis_rd_meta_t rd_meta_s1,
	input  logic [WIDTH-1:0]      rdata,
	output kis_pkg::kis_ob_stat_t ob_stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WIDTH-1:0]      out_data,
	output logic                  out_last,
	output logic                  out_ovf
);

	logic [WIDTH+1:0] ent_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       occ_q;
	logic             pop;
	logic             push;
	logic [2:0]       credit;
	logic [WIDTH+1:0] head;

	assign push      = rd_meta_s1.valid;
	assign pop       = out_valid & out_ready;
	assign out_valid = (occ_q != 2'd0);
	assign head      = ent_q[rd_q];
	assign out_data  = head[WIDTH-1:0];
	assign out_last  = head[WIDTH];
	assign out_ovf   = head[WIDTH+1];

	// entries held after this edge, counting the read already in flight
	assign credit        = {1'b0, occ_q} + {2'b00, push} - {2'b00, pop};
	assign ob_stat.space = (credit < 3'd2);
	assign ob_stat.occ   = occ_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= {rd_meta_s1.ovf, rd_meta_s1.last, rdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			occ_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			occ_q <= credit[1:0];
		end
	end

endmodule

// File: test/tb_key_index_sorter_unit.sv
// self-checking testbench of the key index sorter: directed and random sets against a stable argsort predictor
module tb_key_index_sorter_unit;

	localparam int MAX_N      = kis_pkg::MAX_ITEMS_DEF;
	localparam int TAG_W      = kis_pkg::TAG_BITS_DEF;
	localparam int QUIET_MAX  = 5000;
	localparam int HOLD_CYC   = 400;
	localparam int HOLD_AT    = 22;
	localparam int END_CYC    = 40;

	localparam logic signed [kis_pkg::KEY_BITS-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [kis_pkg::KEY_BITS-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	// one load request as the sender offers it
	typedef struct {
		logic signed [kis_pkg::KEY_BITS-1:0] key;
		logic [kis_pkg::TAG_FIELD_BITS-1:0]  tag;
		logic                                last;
		int                                  gap;
		bit                                  wait_drain;
	} load_req_t;

	// one sorted result as the receiver should see it
	typedef struct {
		logic signed [kis_pkg::KEY_BITS-1:0] key;
		logic [kis_pkg::TAG_FIELD_BITS-1:0]  tag;
		logic                                last;
		logic                                ovf;
	} sorted_entry_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	load_req_t     pending_items[$];
	sorted_entry_t sorted_expect[$];
	load_req_t     cur_item;

	// predictor copy of the set being loaded
	logic signed [kis_pkg::KEY_BITS-1:0] set_keys[MAX_N];
	logic [kis_pkg::TAG_FIELD_BITS-1:0]  set_tags[MAX_N];
	int                                  set_len     = 0;
	bit                                  set_dropped = 0;

	int  errors     = 0;
	int  items_sent = 0;
	int  res_seen   = 0;
	int  send_idle  = 0;
	int  rx_wait    = 0;
	int  hold_left  = 0;
	bit  hold_armed = 1;
	int  quiet      = 0;

	key_index_sorter_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", res_seen, msg);
		errors++;
	endtask

	// store one accepted request, or mark the set overflowed when full; a closing request emits the stably sorted set
	task automatic absorb_item(input load_req_t it);
		logic signed [kis_pkg::KEY_BITS-1:0] k;
		logic [kis_pkg::TAG_FIELD_BITS-1:0]  t;
		int                                  j;
		sorted_entry_t                       r;
		if (set_len < MAX_N) begin
			set_keys[set_len] = it.key;
			set_tags[set_len] = it.tag & kis_pkg::TAG_FIELD_BITS'((1 << TAG_W) - 1);
			set_len++;
		end else begin
			set_dropped = 1;
		end
		if (!it.last)
			return;
		for (int i = 1; i < set_len; i++) begin
			k = set_keys[i];
			t = set_tags[i];
			j = i;
			// strict compare keeps equal keys in arrival order
			while (j > 0 && k < set_keys[j-1]) begin
				set_keys[j] = set_keys[j-1];
				set_tags[j] = set_tags[j-1];
				j--;
			end
			set_keys[j] = k;
			set_tags[j] = t;
		end
		for (int i = 0; i < set_len; i++) begin
			r.key  = set_keys[i];
			r.tag  = set_tags[i];
			r.last = (i == set_len - 1);
			r.ovf  = set_dropped;
			sorted_expect.push_back(r);
		end
		set_len     = 0;
		set_dropped = 0;
	endtask

	task automatic add_req(input logic signed [kis_pkg::KEY_BITS-1:0] key, input int tag,
			input bit last, input int gap, input bit wait_drain);
		load_req_t it;
		it.key        = key;
		it.tag        = kis_pkg::TAG_FIELD_BITS'(tag);
		it.last       = last;
		it.gap        = gap;
		it.wait_drain = wait_drain;
		pending_items.push_back(it);
	endtask

	function automatic logic signed [kis_pkg::KEY_BITS-1:0] pick_key();
		case ($urandom_range(0, 4))
			0: pick_key = {$urandom, $urandom};
			// narrow range so ties come often
			1: pick_key = longint'($urandom_range(0, 8)) - 64'sd4;
			2: pick_key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
			3: pick_key = {($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0), $urandom};
			default: pick_key = {$urandom, $urandom};
		endcase
	endfunction

	// random set of n requests; a burst set offers back to back
	task automatic add_random_set(input int n, input bit wait_drain);
		bit burst;
		burst = ($urandom_range(0, 2) == 0);
		for (int i = 0; i < n; i++)
			add_req(pick_key(), $urandom_range(0, 65535), i == n - 1,
				burst ? 0 : $urandom_range(0, 10), wait_drain && i == 0);
	endtask

	// sender: one request per handshake, each after its own idle gap
	always @(posedge clk) begin
		bit launch;
		launch = 0;
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			send_idle <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				absorb_item(cur_item);
				items_sent <= items_sent + 1;
			end
			if (!(s_tvalid && !s_tready)) begin
				// a request marked to wait holds back until every result has come
				if (pending_items.size() != 0 &&
						!(pending_items[0].wait_drain && sorted_expect.size() != 0)) begin
					if (send_idle >= pending_items[0].gap)
						launch = 1;
					else
						send_idle <= send_idle + 1;
				end
				if (launch) begin
					cur_item = pending_items.pop_front();
					s_tdata   <= {cur_item.tag, cur_item.key};
					s_tlast   <= cur_item.last;
					send_idle <= 0;
				end
				s_tvalid <= launch;
			end
		end
	end

	// one long receiver hold-off so the block fills up and stalls its input
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_armed && items_sent >= HOLD_AT) begin
			hold_left  <= HOLD_CYC;
			hold_armed <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: check every accepted result against the oldest expectation
	always @(posedge clk) begin
		int            nw;
		sorted_entry_t e;
		nw = rx_wait;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sorted_expect.size() == 0) begin
					report_mismatch($sformatf("unexpected result key %0d tag %0d",
						$signed(m_tdata[63:0]), m_tdata[79:64]));
				end else begin
					e = sorted_expect.pop_front();
					if (m_tdata[63:0] !== e.key)
						report_mismatch($sformatf("key %0d, expected %0d",
							$signed(m_tdata[63:0]), e.key));
					if (m_tdata[79:64] !== e.tag)
						report_mismatch($sformatf("tag %0d, expected %0d",
							m_tdata[79:64], e.tag));
					if (m_tlast !== e.last)
						report_mismatch($sformatf("last %b, expected %b", m_tlast, e.last));
					if (m_tuser !== e.ovf)
						report_mismatch($sformatf("overflow %b, expected %b", m_tuser, e.ovf));
				end
				res_seen <= res_seen + 1;
				// every third stretch of results is taken without stalls
				nw = ((res_seen / 48) % 3 == 1) ? 0 : $urandom_range(0, 10);
			end else if (nw > 0) begin
				nw--;
			end
			rx_wait  <= nw;
			m_tready <= (nw == 0) && (hold_left == 0);
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_MAX) begin
			$display("tb_key_index_sorter_unit: FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		// single item set at the top of the key range
		add_req(KEY_MAX, 16'hFFFF, 1, 0, 0);
		// extremes, zero, ones and a tie on -1
		add_req(KEY_MAX, 16'h0000, 0, 3, 0);
		add_req(KEY_MIN, 16'hFFFF, 0, 0, 0);
		add_req(64'sd0, 16'h5555, 0, 1, 0);
		add_req(-64'sd1, 16'hAAAA, 0, 0, 0);
		add_req(64'sd1, 16'h0001, 0, 0, 0);
		add_req(-64'sd1, 16'h8000, 0, 2, 0);
		add_req(KEY_MIN, 16'h0000, 1, 0, 0);
		// descending order, the longest insertion scans; waits for the drain first
		add_req(64'sd500, 16'd10, 0, 0, 1);
		add_req(64'sd400, 16'd11, 0, 0, 0);
		add_req(64'sd3, 16'd12, 0, 0, 0);
		add_req(-64'sd3, 16'd13, 0, 0, 0);
		add_req(KEY_MIN + 64'sd1, 16'd14, 0, 0, 0);
		add_req(KEY_MIN, 16'd15, 1, 0, 0);
		// all keys equal: output must follow arrival order
		add_req(64'sh1234_5678_9ABC_DEF0, 16'd7, 0, 0, 0);
		add_req(64'sh1234_5678_9ABC_DEF0, 16'd3, 0, 4, 0);
		add_req(64'sh1234_5678_9ABC_DEF0, 16'd9, 0, 0, 0);
		add_req(64'sh1234_5678_9ABC_DEF0, 16'd1, 1, 0, 0);
		// small random sets, the long receiver hold-off falls among them
		for (int s = 0; s < 5; s++)
			add_random_set($urandom_range(1, 6), 0);
		// over capacity: the last two requests, the closing one among them, are dropped
		add_random_set(MAX_N + 2, 1);
		for (int s = 0; s < 4; s++)
			add_random_set($urandom_range(1, 6), s == 2);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (sorted_expect.size() != 0)
			@(posedge clk);
		repeat (END_CYC) @(posedge clk);

		if (errors == 0)
			$display("tb_key_index_sorter_unit: PASS");
		else
			$display("tb_key_index_sorter_unit: FAIL");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/kis_pkg.sv
hw/rtl/kis_mem.sv
hw/rtl/kis_ctrl.sv
hw/rtl/kis_outbuf.sv
hw/rtl/key_index_sorter_unit.sv
test/tb_key_index_sorter_unit.sv
